@@ rtl/egcd_pkg.sv @@
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types for the extended GCD block: sequencer states and the status
// bundle returned by the iterative divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package egcd_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_DONE
	} egcd_state_t;

	typedef struct packed {
		logic done;      // quotient/remainder and products are ready this cycle
		logic rem_zero;  // remainder of the finished division is zero
	} egcd_div_stat_t;

endpackage

`default_nettype wire

@@ rtl/egcd_in_if.sv @@
// ----------------------------------------------------------------------------
// egcd_in_if
// Operand channel: valid/ready handshake carrying operands a and b.
// ----------------------------------------------------------------------------
`default_nettype none

interface egcd_in_if #(
	parameter int WIDTH = 32
);

	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] first_value;
	logic [WIDTH-1:0] second_value;

	modport source (output valid, output first_value, output second_value, input ready);
	modport sink   (input valid, input first_value, input second_value, output ready);

endinterface

`default_nettype wire

@@ rtl/egcd_out_if.sv @@
// ----------------------------------------------------------------------------
// egcd_out_if
// Result channel: valid/ready handshake carrying gcd, Bezout coefficients
// and the zero-divisor flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface egcd_out_if #(
	parameter int WIDTH = 32
);

	logic                valid;
	logic                ready;
	logic [WIDTH-1:0]    divisor_value;
	logic signed [WIDTH:0] coeff_first;
	logic signed [WIDTH:0] coeff_second;
	logic                second_was_zero;

	modport source (
		output valid, output divisor_value, output coeff_first,
		output coeff_second, output second_was_zero, input ready
	);
	modport sink (
		input valid, input divisor_value, input coeff_first,
		input coeff_second, input second_was_zero, output ready
	);

endinterface

`default_nettype wire

@@ rtl/egcd_divmac.sv @@
// ----------------------------------------------------------------------------
// egcd_divmac
// Restoring divider, one quotient bit per cycle, MSB first. Each quotient
// bit also feeds two Horner accumulators that build q*sb and q*tb modulo
// 2^(WIDTH+1), so no multiplier is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module egcd_divmac #(
	parameter int WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [WIDTH-1:0]       dividend,
	input  wire logic [WIDTH-1:0]       divisor,
	input  wire logic [WIDTH:0]         coef_s,
	input  wire logic [WIDTH:0]         coef_t,
	output egcd_pkg::egcd_div_stat_t    stat,
	output logic [WIDTH-1:0]            remainder,
	output logic [WIDTH:0]              prod_s,
	output logic [WIDTH:0]              prod_t
);

	import egcd_pkg::*;

	localparam int CntW = $clog2(WIDTH + 1);

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvd_q;
	logic [WIDTH:0]  sacc_q;
	logic [WIDTH:0]  tacc_q;

	logic [WIDTH:0]  trial;
	logic [WIDTH:0]  diff;
	logic            qbit;

	always_comb begin
		trial = {rem_q, dvd_q[WIDTH-1]};
		diff  = trial - {1'b0, divisor};
		qbit  = ~diff[WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvd_q  <= dividend;
			sacc_q <= '0;
			tacc_q <= '0;
		end else if (busy_q) begin
			rem_q  <= qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			dvd_q  <= {dvd_q[WIDTH-2:0], 1'b0};
			// Horner step: acc = 2*acc + qbit*coef
			sacc_q <= {sacc_q[WIDTH-1:0], 1'b0} + (qbit ? coef_s : '0);
			tacc_q <= {tacc_q[WIDTH-1:0], 1'b0} + (qbit ? coef_t : '0);
		end
	end

	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);
	assign remainder     = rem_q;
	assign prod_s        = sacc_q;
	assign prod_t        = tacc_q;

endmodule

`default_nettype wire

@@ rtl/extended_gcd.sv @@
// When b is zero, result valid follows in the cycle after the operand transfer;
// otherwise each Euclid step is a start, then one quotient bit per cycle in the
// shared divider, then the update of the pairs, for about 47 steps worst case
// at WIDTH=32.
// Throughput: one item at a time; ready returns the cycle after the result transfer.
// Reset clears the sequencer and the divider control; no clearing pass.
// ----------------------------------------------------------------------------
// extended_gcd
// Extended Euclidean algorithm: gcd(a,b) and signed X, Y with X*a + Y*b = gcd,
// using one iterative divide/accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module extended_gcd #(
	parameter int WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	egcd_in_if.sink   operands,
	egcd_out_if.source result
);

	import egcd_pkg::*;

	egcd_state_t state_q, state_d;

	logic [WIDTH-1:0] ra_q, rb_q;
	logic [WIDTH:0]   sa_q, sb_q, ta_q, tb_q;
	logic             zf_q;

	logic             in_xfer;
	logic             start;
	logic             update;

	egcd_div_stat_t   div_stat;
	logic [WIDTH-1:0] div_rem;
	logic [WIDTH:0]   div_ps;
	logic [WIDTH:0]   div_pt;

	egcd_divmac #(.WIDTH(WIDTH)) u_divmac (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.dividend  (ra_q),
		.divisor   (rb_q),
		.coef_s    (sb_q),
		.coef_t    (tb_q),
		.stat      (div_stat),
		.remainder (div_rem),
		.prod_s    (div_ps),
		.prod_t    (div_pt)
	);

	assign in_xfer = operands.valid && operands.ready;

	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		update  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (operands.second_value == '0) ? ST_DONE : ST_START;
				end
			end
			ST_START: begin
				start   = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_stat.done) begin
					update  = 1'b1;
					state_d = div_stat.rem_zero ? ST_DONE : ST_START;
				end
			end
			ST_DONE: begin
				if (result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ra_q <= operands.first_value;
			rb_q <= operands.second_value;
			sa_q <= (WIDTH+1)'(1);
			sb_q <= '0;
			ta_q <= '0;
			tb_q <= (WIDTH+1)'(1);
			zf_q <= (operands.second_value == '0);
		end else if (update) begin
			// advance the pairs: new = older - q * newer
			ra_q <= rb_q;
			rb_q <= div_rem;
			sa_q <= sb_q;
			sb_q <= sa_q - div_ps;
			ta_q <= tb_q;
			tb_q <= ta_q - div_pt;
		end
	end

	assign operands.ready         = (state_q == ST_IDLE);
	assign result.valid           = (state_q == ST_DONE);
	assign result.divisor_value   = ra_q;
	assign result.coeff_first     = sa_q;
	assign result.coeff_second    = ta_q;
	assign result.second_was_zero = zf_q;

endmodule

`default_nettype wire
